/* design/assert_macros.svh */
// Assertion macros shared by the lock block's RTL files.
// Each macro checks a property on the rising clock edge and is disabled in reset.
// Define NO_ASSERTIONS to compile all of them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/rmfw_pkg.sv */
// Package for the recursive mutex with FIFO wait queue.
// Holds the sizing constants, the status codes and the queue interface structs.
// No dependencies.
`timescale 1ns / 1ps

package rmfw_pkg;

   // Sizing
   localparam int TID_BITS     = 6;
   localparam int THREAD_COUNT = 64;
   localparam int WAIT_DEPTH   = 16;
   localparam int COUNT_BITS   = 8;
   localparam int PTR_BITS     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int FILL_BITS    = $clog2(WAIT_DEPTH + 1);

   // Requested operation
   typedef enum logic {
      FUNC_ACQUIRE = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   // Result codes
   typedef enum logic [2:0] {
      ST_GRANTED     = 3'd0,
      ST_RECURSED    = 3'd1,
      ST_BLOCKED     = 3'd2,
      ST_DECREMENTED = 3'd3,
      ST_FREED       = 3'd4,
      ST_HANDOFF     = 3'd5,
      ST_ERROR       = 3'd6,
      ST_OVERFLOW    = 3'd7
   } status_type;

   // Commands from the lock logic to the wait queue
   typedef struct packed {
      logic                push;
      logic                pop;
      logic [TID_BITS-1:0] push_tid;
   } queue_ctl_type;

   // Status of the wait queue seen by the lock logic
   typedef struct packed {
      logic                 empty;
      logic                 full;
      logic [FILL_BITS-1:0] fill;
      logic [TID_BITS-1:0]  head_tid;
   } queue_sts_type;

endpackage

/* design/rmfw_queue.sv */
// Wait queue of thread identifiers for the recursive mutex: a circular buffer.
// Depends on rmfw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmfw_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  rmfw_pkg::queue_ctl_type ctl,
   output rmfw_pkg::queue_sts_type sts
);
   import rmfw_pkg::*;

   localparam logic [PTR_BITS-1:0]  LAST_PTR   = PTR_BITS'(WAIT_DEPTH - 1);
   localparam logic [FILL_BITS:0]   DEPTH_WIDE = (FILL_BITS + 1)'(WAIT_DEPTH);
   localparam logic [FILL_BITS-1:0] DEPTH_FILL = FILL_BITS'(WAIT_DEPTH);

   logic [TID_BITS-1:0]  entries_ff [WAIT_DEPTH];
   logic [PTR_BITS-1:0]  head_ff;
   logic [PTR_BITS-1:0]  head_in;
   logic [FILL_BITS-1:0] fill_ff;
   logic [FILL_BITS-1:0] fill_in;
   logic [FILL_BITS:0]   tail_sum;
   logic [PTR_BITS-1:0]  tail_ptr;

   // Tail slot is head plus fill, wrapped once at the queue depth.
   always_comb begin
      tail_sum = (FILL_BITS + 1)'(head_ff) + (FILL_BITS + 1)'(fill_ff);
      if (tail_sum >= DEPTH_WIDE) begin
         tail_sum = tail_sum - DEPTH_WIDE;
      end
      tail_ptr = tail_sum[PTR_BITS-1:0];
   end

   // Head advances on a pop; fill moves by one on a push or a pop.
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctl.pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end else if (ctl.push) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // Entry storage has no reset: only written slots are ever read.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entries_ff[tail_ptr] <= ctl.push_tid;
      end
   end

   always_comb begin
      sts.empty    = (fill_ff == '0);
      sts.full     = (fill_ff == DEPTH_FILL);
      sts.fill     = fill_ff;
      sts.head_tid = entries_ff[head_ff];
   end

   // The lock logic must never push into a full queue or pop an empty one.
   `ASSERT_IMPLIES(a_no_push_full, clock, reset, ctl.push, !sts.full)
   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, ctl.pop, !sts.empty)
   `ASSERT_IMPLIES(a_no_push_and_pop, clock, reset, ctl.push, !ctl.pop)
   `ASSERT_NEXT(a_fill_grows, clock, reset, ctl.push,
                fill_ff == FILL_BITS'($past(fill_ff) + 1'b1))
endmodule

/* design/recursive_mutex_fifo_waiters_unit.sv */
// Recursive mutex with a FIFO wait queue: top level.
// Depends on rmfw_pkg, rmfw_queue and assert_macros.svh.
//
// Usage:
// Each request beat on the req_ channel carries an operation (req_func: acquire or
// release) and the requesting thread (req_thread_id). Exactly one response beat
// per request leaves on the rsp_ channel, in request order, with a status code
// and, on a handoff, the thread that now holds the lock.
// A request is registered on acceptance, evaluated against the lock state and
// queue while it sits in the request register and then lands in the response
// register, from which the response is offered.
// One request is taken every cycle while the receiver does not stall; the figure
// is set by the combinational lock update between the two registers.
// When the receiver stalls, the response register holds its beat; the request
// register still accepts one more beat, after which req_stall is raised until
// the response is taken.
// Synchronous reset frees the lock, clears the recursion count and empties the
// wait queue; queue entries need no clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module recursive_mutex_fifo_waiters_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [rmfw_pkg::TID_BITS-1:0] req_thread_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_woken_valid,
   output logic [rmfw_pkg::TID_BITS-1:0] rsp_woken_thread
);
   import rmfw_pkg::*;

   localparam logic [TID_BITS:0] THREAD_LIMIT = (TID_BITS + 1)'(THREAD_COUNT);

   // Request register
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   func_type              s1_func_ff;
   logic [TID_BITS-1:0]   s1_tid_ff;
   // Lock state
   logic                  held_ff;
   logic                  held_in;
   logic [TID_BITS-1:0]   owner_ff;
   logic [TID_BITS-1:0]   owner_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   // Response register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            status_ff;
   status_type            status_in;
   logic                  woken_valid_ff;
   logic                  woken_valid_in;
   logic [TID_BITS-1:0]   woken_thread_ff;
   logic [TID_BITS-1:0]   woken_thread_in;

   logic                  advance;
   logic                  tid_bad;
   queue_ctl_type         q_ctl;
   queue_sts_type         q_sts;

   // Handshake: the request moves on when the response slot is free or draining.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign tid_bad      = ({1'b0, s1_tid_ff} >= THREAD_LIMIT);

   // Lock decision for the registered request.
   always_comb begin
      held_in         = held_ff;
      owner_in        = owner_ff;
      count_in        = count_ff;
      status_in       = ST_ERROR;
      woken_valid_in  = 1'b0;
      woken_thread_in = '0;
      q_ctl.push      = 1'b0;
      q_ctl.pop       = 1'b0;
      q_ctl.push_tid  = s1_tid_ff;
      if (tid_bad) begin
         status_in = ST_ERROR;
      end else if (s1_func_ff == FUNC_ACQUIRE) begin
         if (!held_ff) begin
            held_in   = 1'b1;
            owner_in  = s1_tid_ff;
            count_in  = '0;
            status_in = ST_GRANTED;
         end else if (owner_ff == s1_tid_ff) begin
            if (count_ff == '1) begin
               status_in = ST_OVERFLOW;
            end else begin
               count_in  = count_ff + 1'b1;
               status_in = ST_RECURSED;
            end
         end else if (q_sts.full) begin
            status_in = ST_OVERFLOW;
         end else begin
            q_ctl.push = advance;
            status_in  = ST_BLOCKED;
         end
      end else begin
         if (!held_ff || owner_ff != s1_tid_ff) begin
            status_in = ST_ERROR;
         end else if (count_ff != '0) begin
            count_in  = count_ff - 1'b1;
            status_in = ST_DECREMENTED;
         end else if (!q_sts.empty) begin
            q_ctl.pop       = advance;
            owner_in        = q_sts.head_tid;
            count_in        = '0;
            status_in       = ST_HANDOFF;
            woken_valid_in  = 1'b1;
            woken_thread_in = q_sts.head_tid;
         end else begin
            held_in   = 1'b0;
            owner_in  = '0;
            count_in  = '0;
            status_in = ST_FREED;
         end
      end
   end

   rmfw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (q_ctl),
      .sts   (q_sts)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= 1'b0;
         owner_ff     <= '0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            held_ff  <= held_in;
            owner_ff <= owner_in;
            count_ff <= count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_func_ff <= func_type'(req_func);
         s1_tid_ff  <= req_thread_id;
      end
      if (advance) begin
         status_ff       <= status_in;
         woken_valid_ff  <= woken_valid_in;
         woken_thread_ff <= woken_thread_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_woken_valid  = woken_valid_ff;
   assign rsp_woken_thread = woken_thread_ff;

   // A free lock carries no owner and no count; a wake-up goes with a handoff only.
   `ASSERT_IMPLIES(a_free_is_clean, clock, reset, !held_ff,
                   owner_ff == '0 && count_ff == '0)
   `ASSERT_IMPLIES(a_woken_on_handoff, clock, reset, rsp_valid_ff,
                   woken_valid_ff == (status_ff == ST_HANDOFF))
   `ASSERT_IMPLIES(a_waiters_need_holder, clock, reset, !q_sts.empty, held_ff)
   `ASSERT_NEXT(a_handoff_owner, clock, reset, advance && status_in == ST_HANDOFF,
                owner_ff == woken_thread_ff && held_ff)
endmodule
